@@ rtl/core/vce_pkg.sv @@
package vce_pkg;

    // letter and word geometry
    localparam int LETTER_W      = 5;
    localparam int WORD_W        = 60;
    localparam int LEN_W         = 4;
    localparam int CHAR_W        = 7;
    localparam int BYTE_W        = 8;
    localparam int MAX_BLOCK_DEF = 12;

    // alphabet constants
    localparam int ALPHABET      = 26;
    localparam int PAD_LETTER    = 23;
    localparam int ASCII_A       = 97;
    localparam int ASCII_Z       = 122;
    localparam int ASCII_UP_A    = 65;
    localparam int ASCII_UP_Z    = 90;
    localparam int CASE_OFFSET   = 32;

    // command queue depth between front and back
    localparam int Q_DEPTH       = 4;

    // apb port geometry
    localparam int APB_DATA_W    = 64;
    localparam int APB_ADDR_W    = 5;
    localparam int REG_LSB       = 3;

    // register indexes
    typedef enum logic [1:0] {
        REG_KEY = 2'd0,
        REG_IV  = 2'd1,
        REG_LEN = 2'd2
    } t_reg_idx;

    // one classified item waiting for the back end
    typedef struct packed {
        logic                is_end;
        logic [LETTER_W-1:0] plain;
    } t_cmd;

    // configuration as seen by the back end
    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] iv;
        logic [LEN_W-1:0]  len;
    } t_cfg;

    // chaining status of the back end
    typedef struct packed {
        logic [LEN_W-1:0] pos;
        logic             past_first;
    } t_back_stat;

endpackage

@@ rtl/core/vce_if.sv @@
interface vce_in_if import vce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              end_marker;

    modport source (output valid, output text_byte, output end_marker, input ready);
    modport sink   (input valid, input text_byte, input end_marker, output ready);
endinterface

interface vce_out_if import vce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] cipher_char;
    logic              is_padding;
    logic              run_last;

    modport source (output valid, output cipher_char, output is_padding, output run_last,
                    input ready);
    modport sink   (input valid, input cipher_char, input is_padding, input run_last,
                    output ready);
endinterface

@@ rtl/core/vce_cfg.sv @@
module vce_cfg import vce_pkg::*; #(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [WORD_W-1:0] r_key, n_key;
    logic [WORD_W-1:0] r_iv, n_iv;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [1:0]        reg_sel;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[APB_ADDR_W-1:REG_LSB];
    assign wr_en   = psel && penable && pwrite && pready;

    // register write decode
    always_comb begin
        n_key = r_key;
        n_iv  = r_iv;
        n_len = r_len;
        if (wr_en) begin
            unique case (reg_sel)
                REG_KEY: n_key = pwdata[WORD_W-1:0];
                REG_IV:  n_iv  = pwdata[WORD_W-1:0];
                REG_LEN: n_len = pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_iv  <= '0;
            r_len <= LEN_W'(1);
        end else begin
            r_key <= n_key;
            r_iv  <= n_iv;
            r_len <= n_len;
        end
    end

    // register read mux
    always_comb begin
        unique case (reg_sel)
            REG_KEY: prdata = APB_DATA_W'(r_key);
            REG_IV:  prdata = APB_DATA_W'(r_iv);
            REG_LEN: prdata = APB_DATA_W'(r_len);
            default: prdata = '0;
        endcase
    end

    // effective block length, clamped to 1..max block
    always_comb begin
        o_cfg.key = r_key;
        o_cfg.iv  = r_iv;
        if (r_len == '0) begin
            o_cfg.len = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_BLOCK)) begin
            o_cfg.len = LEN_W'(MAX_BLOCK);
        end else begin
            o_cfg.len = r_len;
        end
    end

endmodule

@@ rtl/core/vce_front.sv @@
module vce_front import vce_pkg::*; (
    vce_in_if.sink i_in,
    input  logic   i_q_full,
    output logic   o_push,
    output t_cmd   o_cmd
);

    logic [BYTE_W-1:0] lowered;
    logic              is_letter;

    // fold upper case, then keep only a..z
    always_comb begin
        if (i_in.text_byte >= BYTE_W'(ASCII_UP_A) && i_in.text_byte <= BYTE_W'(ASCII_UP_Z)) begin
            lowered = i_in.text_byte + BYTE_W'(CASE_OFFSET);
        end else begin
            lowered = i_in.text_byte;
        end
        is_letter = (lowered >= BYTE_W'(ASCII_A)) && (lowered <= BYTE_W'(ASCII_Z));
    end

    assign i_in.ready = !i_q_full;

    // end markers and letters go to the queue, other bytes are dropped here
    always_comb begin
        o_cmd.is_end = i_in.end_marker;
        if (i_in.end_marker) begin
            o_cmd.plain = LETTER_W'(PAD_LETTER);
        end else begin
            o_cmd.plain = LETTER_W'(lowered - BYTE_W'(ASCII_A));
        end
        o_push = i_in.valid && i_in.ready && (i_in.end_marker || is_letter);
    end

endmodule

@@ rtl/core/vce_queue.sv @@
module vce_queue import vce_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ rtl/core/vce_back.sv @@
module vce_back import vce_pkg::*; #(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_head_valid,
    input  t_cmd         i_head,
    output logic         o_pop,
    output t_back_stat   o_stat,
    vce_out_if.source    o_out
);

    localparam int POS_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_past, n_past;
    logic [LETTER_W-1:0] r_prev [MAX_BLOCK];
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic                r_pad, n_pad;
    logic                r_last, n_last;

    logic                can_emit;
    logic                emit;
    logic                at_boundary;
    logic                wrap;
    logic [LEN_W:0]      pos_inc;
    logic [LETTER_W-1:0] key_l;
    logic [LETTER_W-1:0] chain_l;
    logic [CHAR_W-1:0]   sum;
    logic [LETTER_W-1:0] cipher;

    // letter sum and mod 26 reduction (sum stays below four times 26)
    always_comb begin
        key_l = i_cfg.key[LETTER_W*int'(r_pos) +: LETTER_W];
        if (r_past) begin
            chain_l = r_prev[r_pos];
        end else begin
            chain_l = i_cfg.iv[LETTER_W*int'(r_pos) +: LETTER_W];
        end
        sum = CHAR_W'(key_l) + CHAR_W'(i_head.plain) + CHAR_W'(chain_l);
        if (sum >= CHAR_W'(3 * ALPHABET)) begin
            cipher = LETTER_W'(sum - CHAR_W'(3 * ALPHABET));
        end else if (sum >= CHAR_W'(2 * ALPHABET)) begin
            cipher = LETTER_W'(sum - CHAR_W'(2 * ALPHABET));
        end else if (sum >= CHAR_W'(ALPHABET)) begin
            cipher = LETTER_W'(sum - CHAR_W'(ALPHABET));
        end else begin
            cipher = LETTER_W'(sum);
        end
    end

    // issue control: one emit per letter, one per pad letter of an end marker
    always_comb begin
        can_emit    = !r_out_valid || o_out.ready;
        at_boundary = (r_pos == '0);
        pos_inc     = (LEN_W + 1)'(r_pos) + (LEN_W + 1)'(1);
        wrap        = (pos_inc >= (LEN_W + 1)'(i_cfg.len));
        emit        = i_head_valid && can_emit && !(i_head.is_end && at_boundary);
        if (i_head.is_end) begin
            o_pop = i_head_valid && (at_boundary || (can_emit && wrap));
        end else begin
            o_pop = i_head_valid && can_emit;
        end
    end

    // chaining state
    always_comb begin
        n_pos  = r_pos;
        n_past = r_past;
        if (emit) begin
            n_pos  = wrap ? '0 : POS_W'(pos_inc);
            n_past = wrap ? 1'b1 : r_past;
        end
        if (o_pop && i_head.is_end) begin
            n_pos  = '0;
            n_past = 1'b0;
        end
    end

    // output register
    always_comb begin
        n_char = r_char;
        n_pad  = r_pad;
        n_last = r_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_char      = CHAR_W'(ASCII_A) + CHAR_W'(cipher);
            n_pad       = i_head.is_end;
            n_last      = i_head.is_end && wrap;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_past      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_past      <= n_past;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and previous block letters
    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_pad  <= n_pad;
        r_last <= n_last;
        if (emit) begin
            r_prev[r_pos] <= cipher;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.cipher_char = r_char;
    assign o_out.is_padding  = r_pad;
    assign o_out.run_last    = r_last;

    assign o_stat.pos        = LEN_W'(r_pos);
    assign o_stat.past_first = r_past;

endmodule

@@ rtl/core/vigenere_cbc_encrypt.sv @@
// Vigenere encryptor with block chaining over a byte stream. Input is taken
// while the queue is not full: letters are folded to lower case and queued,
// other bytes are dropped on the spot, and the back end turns one queued
// letter into one ciphertext letter per cycle while the receiver does not
// stall it; each letter passes the queue and then the output register. An end
// marker makes the back end emit padding letters to the end of the block
// (block length minus the current position), or is taken with no output on a
// block boundary; a four-entry queue lets input keep flowing meanwhile. The key,
// IV and block length sit in an APB register file at byte addresses 0, 8 and
// 16. The user must write them only while the block is idle; the block does not enforce it.
module vigenere_cbc_encrypt import vce_pkg::*; #(
    parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    vce_in_if.sink                i_in,
    vce_out_if.source             o_out
);

    t_cfg       cfg;
    t_cmd       push_cmd;
    t_cmd       head;
    t_back_stat stat;
    logic       push;
    logic       q_full;
    logic       head_valid;
    logic       pop;

    // configuration registers
    vce_cfg #(
        .MAX_BLOCK(MAX_BLOCK)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // classify incoming bytes
    vce_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // queue between front and back
    vce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    // encryption and chaining
    vce_back #(
        .MAX_BLOCK(MAX_BLOCK)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_stat       (stat),
        .o_out        (o_out)
    );

    // checks
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.pos < LEN_W'(MAX_BLOCK))
        else $error("block position out of range");

    a_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && head.is_end) |=> (!stat.past_first && stat.pos == '0))
        else $error("chain not restarted after end marker");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.cipher_char >= CHAR_W'(ASCII_A)
                         && o_out.cipher_char <= CHAR_W'(ASCII_Z)))
        else $error("cipher letter out of range");

    a_last_is_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.run_last) |-> o_out.is_padding)
        else $error("run end flag on a text letter");

endmodule

@@ bench/vce_checker.sv @@
module vce_checker import vce_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    vce_in_if                     i_in,
    vce_out_if                    i_out,
    output int                    o_errors,
    output int                    o_pending
);

    // one ciphertext letter as the block should emit it
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              pad;
        logic              last;
    } t_cipher_out;

    // shadow of the register file
    logic [WORD_W-1:0]   key_word;
    logic [WORD_W-1:0]   iv_word;
    logic [LEN_W-1:0]    len_reg;

    // shadow of the chaining state
    int                  blk_pos;
    bit                  past_first;
    logic [LETTER_W-1:0] chain_mem [MAX_BLOCK_DEF];

    t_cipher_out         cipher_due [$];
    int                  err_count = 0;

    // encrypt one letter at the current position and advance the chain
    function automatic logic [CHAR_W-1:0] encipher_letter(input int plain);
        int pos;
        int chain;
        int code;
        int eff;
        pos   = blk_pos % MAX_BLOCK_DEF;
        chain = past_first ? int'(chain_mem[pos]) : int'(iv_word[pos*LETTER_W +: LETTER_W]);
        code  = (int'(key_word[pos*LETTER_W +: LETTER_W]) + plain + chain) % ALPHABET;
        chain_mem[pos] = LETTER_W'(code);
        eff = int'(len_reg);
        if (eff == 0) eff = 1;
        if (eff > MAX_BLOCK_DEF) eff = MAX_BLOCK_DEF;
        if (pos + 1 >= eff) begin
            blk_pos    = 0;
            past_first = 1'b1;
        end else begin
            blk_pos = pos + 1;
        end
        return CHAR_W'(ASCII_A + code);
    endfunction

    always @(posedge i_clk) begin : model
        t_cipher_out    due;
        int             b;
        int             n;
        logic [1:0]     reg_sel;
        if (!i_rst_n) begin
            key_word   = '0;
            iv_word    = '0;
            len_reg    = LEN_W'(1);
            blk_pos    = 0;
            past_first = 1'b0;
            for (int i = 0; i < MAX_BLOCK_DEF; i++) chain_mem[i] = '0;
            cipher_due.delete();
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                reg_sel = paddr[REG_LSB +: 2];
                case (reg_sel)
                    REG_KEY: key_word = pwdata[WORD_W-1:0];
                    REG_IV:  iv_word  = pwdata[WORD_W-1:0];
                    REG_LEN: len_reg  = pwdata[LEN_W-1:0];
                    default: ;
                endcase
            end

            // input transaction: predict what it causes
            if (i_in.valid && i_in.ready) begin
                if (i_in.end_marker) begin
                    n = 0;
                    while (blk_pos != 0 && n < MAX_BLOCK_DEF) begin
                        due.ch   = encipher_letter(PAD_LETTER);
                        due.pad  = 1'b1;
                        due.last = (blk_pos == 0) || (n + 1 == MAX_BLOCK_DEF);
                        cipher_due.push_back(due);
                        n++;
                    end
                    blk_pos    = 0;
                    past_first = 1'b0;
                end else begin
                    b = int'(i_in.text_byte);
                    if (b >= ASCII_UP_A && b <= ASCII_UP_Z) b = b + CASE_OFFSET;
                    if (b >= ASCII_A && b <= ASCII_Z) begin
                        due.ch   = encipher_letter(b - ASCII_A);
                        due.pad  = 1'b0;
                        due.last = 1'b0;
                        cipher_due.push_back(due);
                    end
                end
            end

            // output transaction: compare with the oldest expectation
            if (i_out.valid && i_out.ready) begin
                if (cipher_due.size() == 0) begin
                    err_count++;
                    $error("unexpected result: cipher_char %0d is_padding %0b run_last %0b",
                           i_out.cipher_char, i_out.is_padding, i_out.run_last);
                end else begin
                    due = cipher_due.pop_front();
                    if (i_out.cipher_char !== due.ch) begin
                        err_count++;
                        $error("cipher_char: expected %0d, got %0d", due.ch, i_out.cipher_char);
                    end
                    if (i_out.is_padding !== due.pad) begin
                        err_count++;
                        $error("is_padding: expected %0b, got %0b", due.pad, i_out.is_padding);
                    end
                    if (i_out.run_last !== due.last) begin
                        err_count++;
                        $error("run_last: expected %0b, got %0b", due.last, i_out.run_last);
                    end
                end
            end
        end
        o_errors  <= err_count;
        o_pending <= cipher_due.size();
    end

endmodule

@@ bench/vigenere_cbc_encrypt_tb.sv @@
module vigenere_cbc_encrypt_tb;
    import vce_pkg::*;

    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD    = 300;
    localparam int LIMIT_CYCLES = 500000;
    localparam int PHASE_ITEMS  = 16;
    localparam int NUM_PHASES   = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    chk_errors;
    int                    chk_pending;
    bit                    quiet    = 1'b0;
    bit                    hold_req = 1'b0;

    vce_in_if  in_if ();
    vce_out_if out_if ();

    vigenere_cbc_encrypt dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    vce_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .i_in      (in_if),
        .i_out     (out_if),
        .o_errors  (chk_errors),
        .o_pending (chk_pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #(LIMIT_CYCLES * 10);
        $display("vigenere_cbc_encrypt_tb: errors");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        out_if.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
                out_if.ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                out_if.ready <= 1'b1;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return WORD_W'({$urandom, $urandom});
    endfunction

    // mostly short blocks, sometimes the largest or out of range
    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return LEN_W'($urandom_range(1, 4));
        if (r < 8) return LEN_W'(MAX_BLOCK_DEF);
        return LEN_W'($urandom_range(0, 15));
    endfunction

    // offer one input transaction and wait until it is taken
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic e);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.text_byte  <= b;
        in_if.end_marker <= e;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    task automatic send_letter(input int code);
        send_byte(BYTE_W'(code), 1'b0);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [WORD_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(int'(idx) << REG_LSB);
        pwdata  <= APB_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid, wait for every expected letter, then let the back end finish
    task automatic settle();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // close the message so the chain sits at a block boundary, then reprogram
    task automatic load_config(input logic [WORD_W-1:0] key, input logic [WORD_W-1:0] iv,
                               input logic [LEN_W-1:0] len);
        send_byte(8'h00, 1'b1);
        settle();
        apb_write(REG_KEY, key);
        apb_write(REG_IV, iv);
        apb_write(REG_LEN, WORD_W'(len));
    endtask

    task automatic random_phase(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                send_byte(BYTE_W'($urandom), 1'b1);
            end else if (r < 25) begin
                send_byte(BYTE_W'($urandom), 1'b0);
            end else if (r < 62) begin
                send_letter(ASCII_A + $urandom_range(0, ALPHABET - 1));
            end else begin
                send_letter(ASCII_UP_A + $urandom_range(0, ALPHABET - 1));
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        pready           = 1'b1;
        in_if.valid      = 1'b0;
        in_if.text_byte  = '0;
        in_if.end_marker = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-ones key and iv, longest block: letter and non-letter edges
        load_config({WORD_W{1'b1}}, {WORD_W{1'b1}}, LEN_W'(MAX_BLOCK_DEF));
        send_letter(ASCII_UP_A);
        send_letter(ASCII_Z);
        send_letter(ASCII_UP_Z);
        send_letter(ASCII_A);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_letter(ASCII_UP_A - 1);
        send_letter(ASCII_UP_Z + 1);
        send_letter(ASCII_A - 1);
        send_letter(ASCII_Z + 1);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC1, 1'b0);
        // end marker with a letter byte that must be ignored
        send_byte(8'h71, 1'b1);
        // end marker on a block boundary gives nothing
        send_byte(8'h00, 1'b1);
        // one letter then end: longest padding run
        send_letter(ASCII_A + 12);
        send_byte(8'h00, 1'b1);

        // zero key and iv, block of one
        load_config('0, '0, LEN_W'(1));
        send_letter(ASCII_A + 1);
        send_letter(ASCII_UP_A + 24);
        send_byte(8'h00, 1'b1);

        // length zero acts as one
        load_config(rand_word(), rand_word(), LEN_W'(0));
        send_letter(ASCII_A + 2);
        send_letter(ASCII_A + 3);

        // length fifteen acts as the maximum
        load_config(rand_word(), rand_word(), LEN_W'(15));
        send_letter(ASCII_A + 4);
        send_letter(ASCII_UP_A + 5);
        send_byte(8'h00, 1'b1);

        // random phases, one under a long receiver hold-off, the last one calm
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == NUM_PHASES - 1) quiet = 1'b1;
            load_config(rand_word(), rand_word(), pick_len());
            if (ph == 2) hold_req = 1'b1;
            random_phase(PHASE_ITEMS);
        end

        settle();
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("vigenere_cbc_encrypt_tb: clean");
        end else begin
            $display("vigenere_cbc_encrypt_tb: errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/vce_pkg.sv
rtl/core/vce_if.sv
rtl/core/vce_cfg.sv
rtl/core/vce_front.sv
rtl/core/vce_queue.sv
rtl/core/vce_back.sv
rtl/core/vigenere_cbc_encrypt.sv
bench/vce_checker.sv
bench/vigenere_cbc_encrypt_tb.sv
